@@ rtl/core/radix_page_table_walker_defines.svh @@
// Assertion macros used by the page table walker port checker.
`ifndef RADIX_PAGE_TABLE_WALKER_DEFINES_SVH
`define RADIX_PAGE_TABLE_WALKER_DEFINES_SVH

// Check cons in the same cycle as ante, sampled on clk, off while arst_n is low.
`define RPTW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define RPTW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/rptw_pkg.sv @@
// Types and constants of the radix page table walker.
package rptw_pkg;

	// Field widths fixed by the interface
	localparam int PAGE_W       = 52;
	localparam int VPN_W        = 45;
	localparam int ENTRY_W      = PAGE_W + 1;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 7;
	localparam int ROOT_W       = 6;
	localparam int FIRST_FREE_W = 7;

	// Parameter defaults
	localparam int FRAMES_DEF     = 64;
	localparam int LEVELS_DEF     = 5;
	localparam int INDEX_BITS_DEF = 9;

	// Reset values of the configuration
	localparam int ROOT_RST      = 0;
	localparam int NEXT_FREE_RST = 1;

	typedef enum logic [1:0] {
		CMD_QUERY = 2'd0,
		CMD_MAP   = 2'd1,
		CMD_UNMAP = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_NOMAP   = 2'd1,
		STAT_NOFRAME = 2'd2,
		STAT_OUTSIDE = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROOT_FRAME = 1'd0,
		REG_FIRST_FREE = 1'd1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EVAL
	} walk_state_t;

endpackage

@@ rtl/core/radix_page_table_walker.sv @@
// Radix page table walker: top level with walk sequencer and entry store.
//
// Usage: a command transaction is taken at a rising edge with start high and busy
// low; command, virtual_page and physical_page are sampled there. Each command
// yields exactly one result: done is high for one cycle with found_page and status
// valid in that cycle. The receiver cannot stall; results are never held back.
// Walk: each level reads one table from a single store port in state S_READ
// (address), then S_EVAL (evaluate with optional write-back); done is registered
// from the final S_EVAL. A walk that stops early ends sooner; the unused command
// and a root frame outside the store finish on acceptance, with done in the cycle
// after. busy is low again in the cycle done shows, so the next command can be
// taken while the result is on the ports.
// Configuration is a separate write channel (cfg_valid/cfg_ready, always ready):
// index 0 sets root_frame, index 1 sets first_free_frame and reloads the allocator.
// Reset: the entry store is swept to zero, one entry per cycle, over all
// FRAMES*2^INDEX_BITS entries (32768 by default); busy stays high during the sweep.
// Configuration writes are taken during the sweep.
module radix_page_table_walker #(
	parameter int FRAMES     = rptw_pkg::FRAMES_DEF,
	parameter int LEVELS     = rptw_pkg::LEVELS_DEF,
	parameter int INDEX_BITS = rptw_pkg::INDEX_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  rptw_pkg::cmd_t                     command,
	input  logic [rptw_pkg::VPN_W-1:0]         virtual_page,
	input  logic [rptw_pkg::PAGE_W-1:0]        physical_page,
	output logic                               done,
	output logic [rptw_pkg::PAGE_W-1:0]        found_page,
	output rptw_pkg::status_t                  status,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rptw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rptw_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import rptw_pkg::*;

	localparam int FW      = $clog2(FRAMES);
	localparam int DEPTH   = FRAMES * (2 ** INDEX_BITS);
	localparam int AW      = FW + INDEX_BITS;
	localparam int VA_W    = LEVELS * INDEX_BITS;
	localparam int LVL_W   = $clog2(LEVELS);
	localparam int NF_MIN  = $clog2(FRAMES + 1);
	localparam int NF_W    = (NF_MIN > FIRST_FREE_W) ? NF_MIN : FIRST_FREE_W;

	walk_state_t state_q, state_d;

	logic [AW-1:0]      clr_q;
	logic [ROOT_W-1:0]  root_q;
	logic [NF_W-1:0]    next_free_q;
	logic               done_q;
	logic [PAGE_W-1:0]  found_q;
	status_t            status_q;

	cmd_t               cmd_q;
	logic [VA_W-1:0]    vpn_q;
	logic [PAGE_W-1:0]  ppn_q;
	logic [FW-1:0]      table_q;
	logic [LVL_W-1:0]   lvl_q;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;
	logic [AW-1:0]      walk_addr;
	logic [ENTRY_W-1:0] rd_entry;
	logic [PAGE_W-1:0]  rd_frame;
	logic               rd_valid;
	logic               leaf;

	logic               accept;
	logic               adv;
	logic               alloc;
	logic               fin;
	status_t            fin_status;
	logic [PAGE_W-1:0]  fin_page;
	logic [FW-1:0]      nxt_table;

	// Entry store: {frame, valid}
	rptw_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (walk_addr),
		.rdata (rd_entry)
	);

	assign walk_addr = {table_q, vpn_q[VA_W-1 -: INDEX_BITS]};
	assign rd_valid  = rd_entry[0];
	assign rd_frame  = rd_entry[ENTRY_W-1:1];
	assign leaf      = (lvl_q == LVL_W'(LEVELS - 1));

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done       = done_q;
	assign found_page = found_q;
	assign status     = status_q;

	// Next state, store writes and walk decisions
	always_comb begin
		state_d    = state_q;
		mem_we     = 1'b0;
		mem_waddr  = walk_addr;
		mem_wdata  = '0;
		accept     = 1'b0;
		adv        = 1'b0;
		alloc      = 1'b0;
		fin        = 1'b0;
		fin_status = STAT_OK;
		fin_page   = '0;
		nxt_table  = rd_frame[FW-1:0];
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					accept = 1'b1;
					if (command == CMD_NOP) begin
						fin = 1'b1;
					end else if (32'(root_q) >= 32'(FRAMES)) begin
						fin        = 1'b1;
						fin_status = STAT_OUTSIDE;
					end else begin
						state_d = S_READ;
					end
				end
			end
			S_READ: begin
				state_d = S_EVAL;
			end
			S_EVAL: begin
				if (!leaf) begin
					// Intermediate level: follow, allocate or stop
					if (rd_valid) begin
						if (rd_frame >= PAGE_W'(FRAMES)) begin
							fin        = 1'b1;
							fin_status = STAT_OUTSIDE;
							state_d    = S_IDLE;
						end else begin
							adv     = 1'b1;
							state_d = S_READ;
						end
					end else if (cmd_q == CMD_MAP) begin
						if (32'(next_free_q) >= 32'(FRAMES)) begin
							fin        = 1'b1;
							fin_status = STAT_NOFRAME;
							state_d    = S_IDLE;
						end else begin
							mem_we    = 1'b1;
							mem_wdata = {PAGE_W'(next_free_q), 1'b1};
							alloc     = 1'b1;
							adv       = 1'b1;
							nxt_table = FW'(next_free_q);
							state_d   = S_READ;
						end
					end else begin
						fin        = 1'b1;
						fin_status = STAT_NOMAP;
						state_d    = S_IDLE;
					end
				end else begin
					// Leaf level: read, set or clear the entry
					fin     = 1'b1;
					state_d = S_IDLE;
					case (cmd_q)
						CMD_QUERY: begin
							if (rd_valid) begin
								fin_page = rd_frame;
							end else begin
								fin_status = STAT_NOMAP;
							end
						end
						CMD_MAP: begin
							mem_we    = 1'b1;
							mem_wdata = {ppn_q, 1'b1};
						end
						CMD_UNMAP: begin
							if (rd_valid) begin
								mem_we    = 1'b1;
								mem_wdata = {rd_frame, 1'b0};
							end else begin
								fin_status = STAT_NOMAP;
							end
						end
						default: begin
							fin_status = STAT_OK;
						end
					endcase
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Hold state, sweep counter, configuration and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			root_q      <= ROOT_W'(ROOT_RST);
			next_free_q <= NF_W'(NEXT_FREE_RST);
			done_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
			if (alloc) begin
				next_free_q <= next_free_q + NF_W'(1);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_ROOT_FRAME: root_q      <= cfg_data[ROOT_W-1:0];
					REG_FIRST_FREE: next_free_q <= NF_W'(cfg_data[FIRST_FREE_W-1:0]);
					default:        root_q      <= root_q;
				endcase
			end
		end
	end

	// Latch the command, advance the walk one level at a time and hold the result
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= command;
			vpn_q   <= virtual_page[VA_W-1:0];
			ppn_q   <= physical_page;
			table_q <= FW'(root_q);
			lvl_q   <= '0;
		end else if (adv) begin
			vpn_q   <= vpn_q << INDEX_BITS;
			lvl_q   <= lvl_q + LVL_W'(1);
			table_q <= nxt_table;
		end
		if (fin) begin
			found_q  <= fin_page;
			status_q <= fin_status;
		end
	end

endmodule

@@ rtl/core/rptw_ram.sv @@
// Generic simple dual-port RAM with registered read.
module rptw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry and read one entry; the read data is registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/radix_page_table_walker_checker.sv @@
// Port-level checker of the radix page table walker and its bind.
`include "radix_page_table_walker_defines.svh"

module radix_page_table_walker_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            start,
	input logic                            busy,
	input rptw_pkg::cmd_t                  command,
	input logic [rptw_pkg::VPN_W-1:0]      virtual_page,
	input logic [rptw_pkg::PAGE_W-1:0]     physical_page,
	input logic                            done,
	input logic [rptw_pkg::PAGE_W-1:0]     found_page,
	input rptw_pkg::status_t               status,
	input logic                            cfg_valid,
	input logic                            cfg_ready,
	input logic [rptw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input logic [rptw_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rptw_pkg::*;

	// An accepted transaction either finishes at once or keeps the block busy
	`RPTW_ASSERT_NEXT(a_accept_busy, start && !busy, busy || done, "accepted command lost")
	// A result only follows a walk or a command taken the cycle before
	`RPTW_ASSERT_NOW(a_done_cause, done, $past(busy) || $past(start), "result without command")
	// The walker is free again whenever a result shows
	`RPTW_ASSERT_NOW(a_done_idle, done, !busy, "busy while result shows")
	// Only a successful lookup reports a page
	`RPTW_ASSERT_NOW(a_zero_page, done && status != STAT_OK, found_page == '0, "page on failure")

endmodule

bind radix_page_table_walker radix_page_table_walker_checker u_checker (.*);

@@ dv/page_walk_checker.sv @@
// Scoreboard for the page table walker: mirrors the tables and checks every walk result.
module page_walk_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  rptw_pkg::cmd_t                  command,
	input  logic [rptw_pkg::VPN_W-1:0]      virtual_page,
	input  logic [rptw_pkg::PAGE_W-1:0]     physical_page,
	input  logic                            done,
	input  logic [rptw_pkg::PAGE_W-1:0]     found_page,
	input  rptw_pkg::status_t               status,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [rptw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rptw_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              errors,
	output int                              pending,
	output int                              checked
);
	import rptw_pkg::*;

	localparam int TABLE_SLOTS = 1 << INDEX_BITS_DEF;
	localparam int STORE_DEPTH = FRAMES_DEF * TABLE_SLOTS;
	localparam logic [PAGE_W-1:0] FRAME_LIMIT = PAGE_W'(FRAMES_DEF);

	typedef struct packed {
		logic [PAGE_W-1:0] found;
		status_t           status;
	} walk_result_t;

	// Shadow copy of the physical store and of the walker configuration
	logic [ENTRY_W-1:0] page_mem [STORE_DEPTH];
	logic [ROOT_W-1:0]  root_frame;
	int                 next_free;

	walk_result_t expected_walks [$];
	walk_result_t new_walk;
	walk_result_t oldest;

	// Walk the shadow tables for one command, updating them as the block would
	task automatic predict_walk(input cmd_t c, input logic [VPN_W-1:0] v,
			input logic [PAGE_W-1:0] p, output walk_result_t res);
		logic [PAGE_W-1:0]         tbl;
		logic [ENTRY_W-1:0]        ent;
		logic [INDEX_BITS_DEF-1:0] idx;
		status_t                   st;
		int                        s;
		int                        lvl;
		st = STAT_OK;
		res.found = '0;
		tbl = PAGE_W'(root_frame);
		if (c != CMD_NOP) begin
			if (tbl >= FRAME_LIMIT)
				st = STAT_OUTSIDE;
			// descend through the intermediate levels, building tables on a map
			for (lvl = 0; lvl < LEVELS_DEF - 1 && st == STAT_OK; lvl++) begin
				idx = v[(LEVELS_DEF - 1 - lvl) * INDEX_BITS_DEF +: INDEX_BITS_DEF];
				s = int'(tbl) * TABLE_SLOTS + int'(idx);
				ent = page_mem[s];
				if (ent[0]) begin
					tbl = ent[ENTRY_W-1:1];
					if (tbl >= FRAME_LIMIT)
						st = STAT_OUTSIDE;
				end else if (c == CMD_MAP) begin
					if (next_free >= FRAMES_DEF) begin
						st = STAT_NOFRAME;
					end else begin
						tbl = PAGE_W'(next_free);
						next_free++;
						page_mem[s] = {tbl, 1'b1};
					end
				end else begin
					st = STAT_NOMAP;
				end
			end
			// act on the leaf entry
			if (st == STAT_OK) begin
				s = int'(tbl) * TABLE_SLOTS + int'(v[INDEX_BITS_DEF-1:0]);
				ent = page_mem[s];
				case (c)
					CMD_QUERY: begin
						if (ent[0])
							res.found = ent[ENTRY_W-1:1];
						else
							st = STAT_NOMAP;
					end
					CMD_MAP: page_mem[s] = {p, 1'b1};
					default: begin
						if (ent[0])
							page_mem[s] = {ent[ENTRY_W-1:1], 1'b0};
						else
							st = STAT_NOMAP;
					end
				endcase
			end
		end
		res.status = st;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STORE_DEPTH; i++)
				page_mem[i] = '0;
			root_frame = ROOT_W'(ROOT_RST);
			next_free = NEXT_FREE_RST;
			expected_walks.delete();
			errors = 0;
			pending = 0;
			checked = 0;
		end else begin
			// compare each result with the oldest expected walk
			if (done) begin
				if (expected_walks.size() == 0) begin
					$error("unexpected result: found_page %h status %s", found_page,
						status.name());
					errors++;
				end else begin
					oldest = expected_walks.pop_front();
					checked++;
					if (found_page !== oldest.found) begin
						$error("found_page: expected %h, actual %h", oldest.found, found_page);
						errors++;
					end
					if (status !== oldest.status) begin
						$error("status: expected %s, actual %s", oldest.status.name(),
							status.name());
						errors++;
					end
				end
			end
			// track register writes; first_free also reloads the allocator
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_ROOT_FRAME)
					root_frame = cfg_data[ROOT_W-1:0];
				else
					next_free = int'(cfg_data[FIRST_FREE_W-1:0]);
			end
			// predict each accepted command transaction
			if (start && !busy) begin
				predict_walk(command, virtual_page, physical_page, new_walk);
				expected_walks.push_back(new_walk);
			end
			pending = expected_walks.size();
		end
	end

endmodule

@@ dv/tb_top.sv @@
// Testbench top for the page table walker: stimulus, checker hookup and verdict.
module tb_top;
	import rptw_pkg::*;

	localparam int HALF_PERIOD  = 10;
	localparam int RESET_CYCLES = 9;
	localparam int RANDOM_ITEMS = 950;
	localparam int IDLE_PCT     = 22;
	localparam int DRAIN_CYCLES = 2 * LEVELS_DEF + 4;
	localparam int TABLE_SLOTS  = 1 << INDEX_BITS_DEF;
	localparam int POOL_DEPTH   = 24;
	localparam logic [VPN_W-1:0]  VPN_ALL  = '1;
	localparam logic [PAGE_W-1:0] PAGE_ALL = '1;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	cmd_t                  command;
	logic [VPN_W-1:0]      virtual_page;
	logic [PAGE_W-1:0]     physical_page;
	logic                  done;
	logic [PAGE_W-1:0]     found_page;
	status_t               status;
	logic                  cfg_valid;
	logic                  cfg_ready;
	cfg_reg_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int errors;
	int pending;
	int checked;

	bit               steady;
	int               sent_by_cmd [4];
	int               reg_writes;
	logic [VPN_W-1:0] mapped_pages [$];

	always #HALF_PERIOD clk = ~clk;

	radix_page_table_walker dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.command       (command),
		.virtual_page  (virtual_page),
		.physical_page (physical_page),
		.done          (done),
		.found_page    (found_page),
		.status        (status),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	page_walk_checker walk_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.command       (command),
		.virtual_page  (virtual_page),
		.physical_page (physical_page),
		.done          (done),
		.found_page    (found_page),
		.status        (status),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.errors        (errors),
		.pending       (pending),
		.checked       (checked)
	);

	function automatic bit take_gap();
		return !steady && ($urandom_range(99) < IDLE_PCT);
	endfunction

	// Drive one command transaction and hold it until the walker takes it
	task automatic issue(input cmd_t c, input logic [VPN_W-1:0] v,
			input logic [PAGE_W-1:0] p);
		while (take_gap()) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		command <= c;
		virtual_page <= v;
		physical_page <= p;
		do @(posedge clk); while (busy);
		@(negedge clk);
		sent_by_cmd[int'(c)]++;
	endtask

	// Drive one register write transaction
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		while (take_gap()) begin
			cfg_valid <= 1'b0;
			@(negedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		reg_writes++;
	endtask

	// Hold off commands until every walk has reported
	task automatic settle();
		start <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	initial begin
		int               r;
		int               k;
		int               phase;
		int               phase_len;
		int               total;
		cmd_t             c;
		logic [VPN_W-1:0] v;
		logic [PAGE_W-1:0] p;
		logic [63:0]      raw;

		arst_n = 1'b0;
		start = 1'b0;
		command = CMD_QUERY;
		virtual_page = '0;
		physical_page = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_ROOT_FRAME;
		cfg_data = '0;
		steady = 1'b0;
		reg_writes = 0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// baseline: root in frame 0, allocator from frame 1
		write_reg(REG_ROOT_FRAME, 7'd0);
		write_reg(REG_FIRST_FREE, 7'd1);
		cfg_valid <= 1'b0;

		// empty tables, then full paths at both index extremes
		issue(CMD_QUERY, '0, '0);
		issue(CMD_UNMAP, '0, '0);
		issue(CMD_MAP, '0, PAGE_ALL);
		issue(CMD_QUERY, '0, '0);
		issue(CMD_MAP, VPN_ALL, '0);
		issue(CMD_QUERY, VPN_ALL, PAGE_ALL);
		issue(CMD_UNMAP, VPN_ALL, '0);
		issue(CMD_QUERY, VPN_ALL, '0);
		issue(CMD_UNMAP, VPN_ALL, '0);
		issue(CMD_NOP, VPN_ALL, PAGE_ALL);
		issue(CMD_MAP, 45'd1, 52'd5);
		issue(CMD_QUERY, 45'd1, '0);
		settle();

		// root on a leaf table: huge frames fall outside, allocator exhausted
		write_reg(REG_ROOT_FRAME, 7'd4);
		write_reg(REG_FIRST_FREE, 7'd64);
		cfg_valid <= 1'b0;
		issue(CMD_QUERY, '0, '0);
		issue(CMD_MAP, {9'd1, 36'd0}, 52'd9);
		issue(CMD_MAP, {9'd300, 36'd0}, 52'd9);
		settle();

		// allocator runs dry in the middle of a map
		write_reg(REG_ROOT_FRAME, 7'd63);
		write_reg(REG_FIRST_FREE, 7'd62);
		cfg_valid <= 1'b0;
		issue(CMD_MAP, {9'd7, 9'd8, 9'd9, 9'd10, 9'd11}, 52'd33);
		issue(CMD_QUERY, {9'd7, 9'd8, 9'd9, 9'd10, 9'd11}, '0);
		issue(CMD_UNMAP, {9'd7, 9'd8, 9'd9, 9'd10, 9'd11}, '0);
		settle();

		// allocator hands out frames already in use, the old root among them
		write_reg(REG_FIRST_FREE, 7'd0);
		cfg_valid <= 1'b0;
		issue(CMD_MAP, {9'd7, 9'd8, 9'd9, 9'd10, 9'd11}, 52'd17);
		issue(CMD_QUERY, {9'd7, 9'd8, 9'd9, 9'd10, 9'd11}, '0);
		settle();

		// random phases, each after a chance to rewrite the registers
		total = 0;
		phase = 0;
		while (total < RANDOM_ITEMS) begin
			settle();
			r = $urandom_range(99);
			if (r < 70) begin
				r = $urandom_range(99);
				if (r < 45)
					write_reg(REG_ROOT_FRAME, 7'd0);
				else if (r < 55)
					write_reg(REG_ROOT_FRAME, 7'd63);
				else
					write_reg(REG_ROOT_FRAME, CFG_DATA_W'($urandom_range(63)));
			end
			if ($urandom_range(99) < 80) begin
				r = $urandom_range(99);
				if (r < 8)
					write_reg(REG_FIRST_FREE, 7'd64);
				else if (r < 14)
					write_reg(REG_FIRST_FREE, 7'd0);
				else
					write_reg(REG_FIRST_FREE, CFG_DATA_W'($urandom_range(24, 1)));
			end
			cfg_valid <= 1'b0;
			steady = (phase == 5);
			phase_len = $urandom_range(70, 30);
			for (int n = 0; n < phase_len && total < RANDOM_ITEMS; n++) begin
				r = $urandom_range(99);
				if (r < 36)
					c = CMD_MAP;
				else if (r < 72)
					c = CMD_QUERY;
				else if (r < 93)
					c = CMD_UNMAP;
				else
					c = CMD_NOP;
				// mostly revisit mapped pages or shared prefixes so walks go deep
				r = $urandom_range(99);
				raw = {$urandom, $urandom};
				if (r < 45 && mapped_pages.size() > 0) begin
					v = mapped_pages[$urandom_range(mapped_pages.size() - 1)];
					if ($urandom_range(3) == 0)
						v[INDEX_BITS_DEF-1:0] = INDEX_BITS_DEF'($urandom_range(TABLE_SLOTS - 1));
				end else if (r < 60) begin
					v = raw[VPN_W-1:0];
				end else begin
					for (k = 0; k < LEVELS_DEF; k++) begin
						case ($urandom_range(4))
							0: v[k * INDEX_BITS_DEF +: INDEX_BITS_DEF] = '0;
							1: v[k * INDEX_BITS_DEF +: INDEX_BITS_DEF] = '1;
							2: v[k * INDEX_BITS_DEF +: INDEX_BITS_DEF] =
								INDEX_BITS_DEF'($urandom_range(3));
							default: v[k * INDEX_BITS_DEF +: INDEX_BITS_DEF] =
								INDEX_BITS_DEF'($urandom_range(TABLE_SLOTS - 1));
						endcase
					end
				end
				// small pages alias table frames, wide ones land outside the store
				r = $urandom_range(99);
				raw = {$urandom, $urandom};
				if (r < 50)
					p = PAGE_W'($urandom_range(80));
				else if (r < 85)
					p = raw[PAGE_W-1:0];
				else if (r < 93)
					p = PAGE_ALL;
				else
					p = '0;
				if (c == CMD_MAP) begin
					mapped_pages.push_back(v);
					if (mapped_pages.size() > POOL_DEPTH)
						mapped_pages.delete(0);
				end
				issue(c, v, p);
				total++;
			end
			phase++;
		end
		steady = 1'b0;

		// drain, then allow a full walk for any stray result
		settle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Sent %0d commands: %0d query, %0d map, %0d unmap, %0d unused code.",
			sent_by_cmd[0] + sent_by_cmd[1] + sent_by_cmd[2] + sent_by_cmd[3],
			sent_by_cmd[0], sent_by_cmd[1], sent_by_cmd[2], sent_by_cmd[3]);
		$display("%0d register writes over %0d phases, %0d walk results compared.",
			reg_writes, phase, checked);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Watchdog: well past the store sweep plus the slowest full run
	initial begin
		#8000000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ radix_page_table_walker.f @@
+incdir+rtl/core
rtl/core/rptw_pkg.sv
rtl/core/rptw_ram.sv
rtl/core/radix_page_table_walker.sv
rtl/core/radix_page_table_walker_checker.sv
dv/page_walk_checker.sv
dv/tb_top.sv
